FILE: rtl/multi_list_node_pool_top_defines.svh
// ----------------------------------------------------------------------------
// multi list node pool assertion macros
// concurrent assertion shorthands used by the checker file
// ----------------------------------------------------------------------------
`ifndef MULTI_LIST_NODE_POOL_TOP_DEFINES_SVH
`define MULTI_LIST_NODE_POOL_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define MLNP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define MLNP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/mlnp_pkg.sv
// ----------------------------------------------------------------------------
// mlnp_pkg
// shared sizes, codes, payload and control types of the node pool
// ----------------------------------------------------------------------------
package mlnp_pkg;

    localparam int NUM_LISTS  = 256;
    localparam int POOL_NODES = 4096;
    localparam int DATA_WIDTH = 32;

    localparam int LIST_W  = $clog2(NUM_LISTS);
    localparam int NODE_W  = $clog2(POOL_NODES);
    localparam int PTR_W   = NODE_W + 1;
    localparam int LIMIT_W = 9;
    localparam int OP_W    = 2;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 2'd0,
        OP_READ   = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_RANGE   = 2'd1,
        ST_INVALID = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_APP_LINK,
        S_RD_NODE,
        S_RESP
    } state_t;

    typedef struct packed {
        logic [OP_W-1:0]       opcode;
        logic [LIST_W-1:0]     list_index;
        logic                  from_head;
        logic [NODE_W-1:0]     start_node;
        logic [DATA_WIDTH-1:0] data_in;
    } in_item_t;

    typedef struct packed {
        logic [1:0]            status;
        logic [DATA_WIDTH-1:0] data_out;
        logic [NODE_W-1:0]     next_node;
    } out_item_t;

    typedef struct packed {
        logic    cap_item;
        logic    app_start;
        logic    app_link;
        logic    head_rd;
        logic    node_rd;
        logic    clear_all;
        logic    st_set;
        status_t st_code;
        logic    mem_sel;
        logic    out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] opcode;
        logic            in_range;
        logic            pool_full;
        logic            node_ok;
        logic            out_free;
    } dp_stat_t;

endpackage

FILE: rtl/mlnp_datapath.sv
// ----------------------------------------------------------------------------
// mlnp_datapath
// list tables, node pool memories, allocation pointer and result register
// ----------------------------------------------------------------------------
module mlnp_datapath
    import mlnp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  in_item_t           in_item,
    input  logic               cfg_valid,
    input  logic [LIMIT_W-1:0] cfg_data,
    input  ctrl_cmd_t          cmd,
    output dp_stat_t           stat,
    output logic               out_valid,
    output out_item_t          out_item,
    input  logic               out_ready
);

    in_item_t              item_reg;
    logic [LIMIT_W-1:0]    limit_reg;
    logic [NUM_LISTS-1:0]  valid_reg;
    logic [NUM_LISTS-1:0]  valid_next;
    logic [PTR_W-1:0]      alloc_reg;
    logic [PTR_W-1:0]      alloc_next;
    logic                  was_valid_reg;
    logic [NODE_W-1:0]     new_node_reg;

    logic [NODE_W-1:0]     head_mem [NUM_LISTS];
    logic [NODE_W-1:0]     tail_mem [NUM_LISTS];
    logic [DATA_WIDTH-1:0] data_mem [POOL_NODES];
    logic [NODE_W-1:0]     link_mem [POOL_NODES];

    logic [NODE_W-1:0]     head_rd_reg;
    logic [NODE_W-1:0]     tail_rd_reg;
    logic [DATA_WIDTH-1:0] data_rd_reg;
    logic [NODE_W-1:0]     link_rd_reg;

    status_t               st_reg;
    logic                  mem_sel_reg;
    logic                  out_valid_reg;
    out_item_t             out_reg;

    logic [LIST_W-1:0]     li;
    logic [LIMIT_W-1:0]    li_ext;
    logic [NODE_W-1:0]     nn;
    logic                  cur_valid;
    logic [NODE_W-1:0]     sel_node;
    logic                  out_free;

    assign li        = item_reg.list_index;
    assign li_ext    = {{(LIMIT_W-LIST_W){1'b0}}, li};
    assign nn        = alloc_reg[NODE_W-1:0];
    assign cur_valid = valid_reg[li];
    assign out_free  = !out_valid_reg || out_ready;

    // a read from the head of an empty list lands on node 0
    assign sel_node = item_reg.from_head ? (cur_valid ? head_rd_reg : '0)
                                         : item_reg.start_node;

    always_comb
    begin
        stat.opcode    = item_reg.opcode;
        stat.in_range  = (li_ext < LIMIT_W'(NUM_LISTS))
                         && ((limit_reg == '0) || (li_ext < limit_reg));
        stat.pool_full = alloc_reg >= PTR_W'(POOL_NODES);
        stat.node_ok   = (sel_node != '0) && ({1'b0, sel_node} < alloc_reg);
        stat.out_free  = out_free;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap_item)
        begin
            item_reg <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= '0;
        end
        else if (cfg_valid)
        begin
            limit_reg <= cfg_data;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        alloc_next = alloc_reg;
        if (cmd.clear_all)
        begin
            valid_next = '0;
            alloc_next = PTR_W'(1);
        end
        else if (cmd.app_start)
        begin
            valid_next[li] = 1'b1;
            alloc_next     = alloc_reg + PTR_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            alloc_reg <= PTR_W'(1);
        end
        else
        begin
            valid_reg <= valid_next;
            alloc_reg <= alloc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.app_start)
        begin
            was_valid_reg <= cur_valid;
            new_node_reg  <= nn;
        end
    end

    // head table: set on the first append, read for a head walk
    always_ff @(posedge clk)
    begin
        if (cmd.app_start && !cur_valid)
        begin
            head_mem[li] <= nn;
        end
        if (cmd.head_rd)
        begin
            head_rd_reg <= head_mem[li];
        end
    end

    // tail table: old tail comes out while the new one goes in
    always_ff @(posedge clk)
    begin
        if (cmd.app_start)
        begin
            tail_mem[li] <= nn;
            tail_rd_reg  <= tail_mem[li];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.app_start)
        begin
            data_mem[nn] <= item_reg.data_in;
        end
        if (cmd.node_rd)
        begin
            data_rd_reg <= data_mem[sel_node];
        end
    end

    // new node ends its list, then the old tail points at it
    always_ff @(posedge clk)
    begin
        if (cmd.app_start)
        begin
            link_mem[nn] <= '0;
        end
        else if (cmd.app_link && was_valid_reg)
        begin
            link_mem[tail_rd_reg] <= new_node_reg;
        end
        if (cmd.node_rd)
        begin
            link_rd_reg <= link_mem[sel_node];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.st_set)
        begin
            st_reg      <= cmd.st_code;
            mem_sel_reg <= cmd.mem_sel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_reg.status    <= st_reg;
            out_reg.data_out  <= mem_sel_reg ? data_rd_reg : '0;
            out_reg.next_node <= mem_sel_reg ? link_rd_reg : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

FILE: rtl/mlnp_ctrl.sv
// ----------------------------------------------------------------------------
// mlnp_ctrl
// sequencer stepping one item through the pool memories
// ----------------------------------------------------------------------------
module mlnp_ctrl
    import mlnp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  dp_stat_t  stat,
    output ctrl_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (stat.opcode)
                    OP_APPEND:
                    begin
                        if (stat.in_range && !stat.pool_full)
                        begin
                            state_next = S_APP_LINK;
                        end
                        else
                        begin
                            state_next = S_RESP;
                        end
                    end
                    OP_READ:
                    begin
                        state_next = stat.in_range ? S_RD_NODE : S_RESP;
                    end
                    default:
                    begin
                        state_next = S_RESP;
                    end
                endcase
            end
            S_APP_LINK:
            begin
                state_next = S_RESP;
            end
            S_RD_NODE:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        cmd.st_code = ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.cap_item = in_valid;
            end
            S_EXEC:
            begin
                cmd.st_set = 1'b1;
                unique case (stat.opcode)
                    OP_APPEND:
                    begin
                        priority if (!stat.in_range)
                        begin
                            cmd.st_code = ST_RANGE;
                        end
                        else if (stat.pool_full)
                        begin
                            cmd.st_code = ST_FULL;
                        end
                        else
                        begin
                            cmd.app_start = 1'b1;
                        end
                    end
                    OP_READ:
                    begin
                        if (!stat.in_range)
                        begin
                            cmd.st_code = ST_RANGE;
                        end
                        else
                        begin
                            cmd.head_rd = 1'b1;
                        end
                    end
                    OP_CLEAR:
                    begin
                        cmd.clear_all = 1'b1;
                    end
                    default:
                    begin
                        cmd.st_code = ST_OK;
                    end
                endcase
            end
            S_APP_LINK:
            begin
                cmd.app_link = 1'b1;
            end
            S_RD_NODE:
            begin
                cmd.st_set = 1'b1;
                if (stat.node_ok)
                begin
                    cmd.node_rd = 1'b1;
                    cmd.mem_sel = 1'b1;
                end
                else
                begin
                    cmd.st_code = ST_INVALID;
                end
            end
            S_RESP:
            begin
                cmd.out_load = stat.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

FILE: rtl/multi_list_node_pool_top.sv
// ----------------------------------------------------------------------------
// multi_list_node_pool_top
// many singly linked lists kept in one shared node pool
// ----------------------------------------------------------------------------
// in channel (in_valid/in_ready/in_item) takes append, read and clear items;
// out channel (out_valid/out_ready/out_item) returns one result per item.
// cfg channel writes list_limit; it is always ready, write only when idle.
// one item is worked at a time: accept, execute, a second memory step, then
// the result register is loaded. append and read take the second step (link
// write or node read); range errors, pool full, clear and unused codes go
// from execute straight to the result load. the next item is accepted only
// after the result is loaded, so no new item is taken while one is in work.
// the controller path is: idle, execute, link write or node read, result
// load; a read walks head table then node memories.
// reset empties all lists at once through per-list valid bits and sets the
// allocation pointer to 1; there is no clearing pass. node memories are not
// cleared, unallocated nodes are never read.
// a stalled receiver holds the result in the output register; one more item
// is accepted and worked, then the block waits in its result step with
// in_ready low until the held result is taken.
// ----------------------------------------------------------------------------
module multi_list_node_pool_top
    import mlnp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  in_item_t           in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output out_item_t          out_item,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [LIMIT_W-1:0] cfg_data
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    assign cfg_ready = 1'b1;

    mlnp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mlnp_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_item  (out_item),
        .out_ready (out_ready)
    );

endmodule

FILE: rtl/mlnp_checker.sv
// ----------------------------------------------------------------------------
// mlnp_checker
// port-level checks of the node pool, bound to the top level
// ----------------------------------------------------------------------------
`include "multi_list_node_pool_top_defines.svh"

module mlnp_checker
    import mlnp_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_item
);

    `MLNP_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped under stall")
    `MLNP_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(out_item), "result changed under stall")
    `MLNP_ASSERT_NXT(a_one_item, in_valid && in_ready, !in_ready, "second item taken while busy")
    `MLNP_ASSERT_IMP(a_err_zero, out_valid && (out_item.status != ST_OK), (out_item.data_out == '0) && (out_item.next_node == '0), "error result carries data")

endmodule

bind multi_list_node_pool_top mlnp_checker u_checker (.*);

FILE: tb/multi_list_node_pool_top_test.sv
// ----------------------------------------------------------------------------
// multi_list_node_pool_top_test
// drives append, read, clear and spare-code items into the node pool and
// checks every result against a cycle-free model of the lists; covers empty
// lists, invalid nodes, list limits and a long output stall
// ----------------------------------------------------------------------------
module multi_list_node_pool_top_test;
    import mlnp_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    class node_pool_scoreboard;
        logic [NODE_W-1:0]     head_tab [NUM_LISTS];
        logic [NODE_W-1:0]     tail_tab [NUM_LISTS];
        bit                    live [NUM_LISTS];
        logic [DATA_WIDTH-1:0] data_mem [POOL_NODES];
        logic [NODE_W-1:0]     link_mem [POOL_NODES];
        int                    next_free;
        logic [LIMIT_W-1:0]    limit;
        out_item_t             expected_replies [$];
        int                    errors;

        function new();
            foreach (head_tab[i]) begin
                head_tab[i] = '0;
                tail_tab[i] = '0;
                live[i]     = 1'b0;
            end
            foreach (data_mem[i]) begin
                data_mem[i] = '0;
                link_mem[i] = '0;
            end
            next_free = 1;
            limit     = '0;
            errors    = 0;
        endfunction

        function void set_limit(logic [LIMIT_W-1:0] v);
            limit = v;
        endfunction

        function bit usable(int li);
            return li < NUM_LISTS && (limit == 0 || li < int'(limit));
        endfunction

        // advances the list state by one item and returns its result
        function out_item_t pool_response(in_item_t req);
            out_item_t res;
            int        li;
            int        node;
            res = '0;
            li  = int'(req.list_index);
            case (req.opcode)
                OP_APPEND: begin
                    if (!usable(li))
                        res.status = ST_RANGE;
                    else if (next_free >= POOL_NODES)
                        res.status = ST_FULL;
                    else
                    begin
                        node = next_free;
                        next_free++;
                        data_mem[node] = req.data_in;
                        link_mem[node] = '0;
                        if (live[li])
                            link_mem[tail_tab[li]] = NODE_W'(node);
                        else
                        begin
                            head_tab[li] = NODE_W'(node);
                            live[li]     = 1'b1;
                        end
                        tail_tab[li] = NODE_W'(node);
                        res.status   = ST_OK;
                    end
                end
                OP_READ: begin
                    if (!usable(li))
                        res.status = ST_RANGE;
                    else
                    begin
                        if (req.from_head)
                            node = live[li] ? int'(head_tab[li]) : 0;
                        else
                            node = int'(req.start_node);
                        if (node == 0 || node >= next_free)
                            res.status = ST_INVALID;
                        else
                        begin
                            res.status    = ST_OK;
                            res.data_out  = data_mem[node];
                            res.next_node = link_mem[node];
                        end
                    end
                end
                OP_CLEAR: begin
                    foreach (live[i])
                        live[i] = 1'b0;
                    next_free  = 1;
                    res.status = ST_OK;
                end
                default: res.status = ST_OK;
            endcase
            return res;
        endfunction

        function void note_request(in_item_t req);
            expected_replies.push_back(pool_response(req));
        endfunction

        function void check_reply(out_item_t got);
            out_item_t exp;
            if (expected_replies.size() == 0)
            begin
                $display("%0t: unexpected result status=%0d data=%h next=%0d",
                         $time, got.status, got.data_out, got.next_node);
                errors++;
                return;
            end
            exp = expected_replies.pop_front();
            if (got.status !== exp.status)
            begin
                $display("%0t: status expected %0d actual %0d",
                         $time, exp.status, got.status);
                errors++;
            end
            if (got.data_out !== exp.data_out)
            begin
                $display("%0t: data_out expected %h actual %h",
                         $time, exp.data_out, got.data_out);
                errors++;
            end
            if (got.next_node !== exp.next_node)
            begin
                $display("%0t: next_node expected %0d actual %0d",
                         $time, exp.next_node, got.next_node);
                errors++;
            end
        endfunction

        function int pending();
            return expected_replies.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    in_item_t           in_item;
    logic               out_valid;
    logic               out_ready;
    out_item_t          out_item;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [LIMIT_W-1:0] cfg_data;

    node_pool_scoreboard sb;
    bit                  src_idle;
    bit                  sink_idle;
    bit                  hold_long_req;

    multi_list_node_pool_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #6_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // result side: random stalls, one long hold on request
    initial
    begin : sink_proc
        int n;
        out_ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_long_req)
            begin
                hold_long_req = 1'b0;
                out_ready <= 1'b0;
                repeat (150) @(posedge clk);
            end
            else if (sink_idle && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                n = $urandom_range(1, 5);
                repeat (n) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_reply(out_item);
    end

    function automatic in_item_t request(logic [OP_W-1:0] op, int li, bit fh, int sn,
                                         logic [DATA_WIDTH-1:0] d);
        in_item_t req;
        req.opcode     = op;
        req.list_index = LIST_W'(li);
        req.from_head  = fh;
        req.start_node = NODE_W'(sn);
        req.data_in    = d;
        return req;
    endfunction

    // mostly well-formed traffic on a few lists, some noise
    function automatic in_item_t random_request(int usable_lists, int ptr);
        in_item_t req;
        int       pick;
        int       span;
        req.data_in    = $urandom;
        req.list_index = LIST_W'($urandom_range(0, NUM_LISTS - 1));
        req.from_head  = 1'($urandom_range(0, 1));
        req.start_node = NODE_W'($urandom_range(0, POOL_NODES - 1));
        pick = $urandom_range(0, 99);
        if (pick < 48)
            req.opcode = OP_APPEND;
        else if (pick < 92)
            req.opcode = OP_READ;
        else if (pick < 95)
            req.opcode = OP_CLEAR;
        else if (pick < 98)
            req.opcode = OP_SPARE;
        else
        begin
            req.opcode = OP_W'($urandom_range(0, 3));
            return req;
        end
        span = usable_lists < 8 ? usable_lists : 8;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            req.list_index = LIST_W'($urandom_range(0, span - 1));
        else if (pick < 85)
            req.list_index = LIST_W'($urandom_range(0, usable_lists - 1));
        if (req.opcode == OP_READ)
        begin
            req.from_head = $urandom_range(0, 9) < 6;
            pick = $urandom_range(0, 9);
            if (pick < 7 && ptr > 1)
                req.start_node = NODE_W'($urandom_range(1, ptr - 1));
            else if (pick == 7)
                req.start_node = NODE_W'(ptr < POOL_NODES ? ptr : 0);
        end
        return req;
    endfunction

    task automatic push_request(in_item_t req);
        int n;
        if (src_idle && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            n = $urandom_range(1, 5);
            repeat (n) @(posedge clk);
        end
        in_item  <= req;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_request(req);
    endtask

    task automatic drain();
        int waited;
        in_valid <= 1'b0;
        waited = 0;
        while (sb.pending() > 0 && waited < 2000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic write_limit(logic [LIMIT_W-1:0] v);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sb.set_limit(v);
    endtask

    initial
    begin : stim_proc
        logic [LIMIT_W-1:0] phase_limit [0:4];
        int                 usable_lists;
        sb            = new();
        src_idle      = 1'b1;
        sink_idle     = 1'b1;
        hold_long_req = 1'b0;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_item   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty pool, first nodes, links, spare code and clear
        push_request(request(OP_READ, 0, 1'b1, 0, '0));
        push_request(request(OP_READ, 0, 1'b0, 0, '0));
        push_request(request(OP_READ, 0, 1'b0, POOL_NODES - 1, '0));
        push_request(request(OP_APPEND, 0, 1'b0, 0, '0));
        push_request(request(OP_APPEND, 0, 1'b0, 0, '1));
        push_request(request(OP_APPEND, NUM_LISTS - 1, 1'b0, 0, 32'ha5a5_5a5a));
        push_request(request(OP_READ, 0, 1'b1, 0, '0));
        push_request(request(OP_READ, 0, 1'b0, 2, '0));
        push_request(request(OP_READ, NUM_LISTS - 1, 1'b1, 0, '0));
        push_request(request(OP_READ, 0, 1'b0, 4, '0));
        push_request(request(OP_SPARE, 7, 1'b1, 3, '1));
        push_request(request(OP_CLEAR, 0, 1'b0, 0, '0));
        push_request(request(OP_READ, 0, 1'b1, 0, '0));
        push_request(request(OP_READ, 0, 1'b0, 1, '0));
        drain();

        // one usable list
        write_limit(9'd1);
        push_request(request(OP_APPEND, 1, 1'b0, 0, 32'h1234_5678));
        push_request(request(OP_READ, 1, 1'b1, 0, '0));
        push_request(request(OP_APPEND, 0, 1'b0, 0, 32'h8765_4321));
        push_request(request(OP_READ, NUM_LISTS - 1, 1'b0, 1, '0));
        drain();
        write_limit(9'd256);
        push_request(request(OP_APPEND, NUM_LISTS - 1, 1'b0, 0, 32'hdead_beef));
        push_request(request(OP_READ, NUM_LISTS - 1, 1'b0, 2, '0));
        drain();

        phase_limit[0] = 9'd0;
        phase_limit[1] = 9'd256;
        phase_limit[2] = 9'd3;
        phase_limit[3] = LIMIT_W'($urandom_range(2, 255));
        phase_limit[4] = 9'd511;
        for (int p = 0; p < 5; p++)
        begin
            write_limit(phase_limit[p]);
            usable_lists = (phase_limit[p] == 0 || phase_limit[p] > NUM_LISTS) ?
                           NUM_LISTS : int'(phase_limit[p]);
            src_idle  = p < 4;
            sink_idle = p < 4;
            // stall the result side long enough that the block backs up
            if (p == 1)
                hold_long_req = 1'b1;
            for (int i = 0; i < 170; i++)
                push_request(random_request(usable_lists, sb.next_free));
            drain();
        end

        if (sb.pending() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
